// File: rtl/core/ndld_pkg.sv
// ----------------------------------------------------------------------------
// ndld_pkg
// Shared widths, prefix codes and the decode control struct of the
// skip and difference list decoder.
// ----------------------------------------------------------------------------
package ndld_pkg;

	localparam int OUT_POS_W = 24;
	localparam int LEN_W     = 24;
	localparam int BYTE_W    = 8;
	localparam int CODE_W    = 2;
	localparam int SKIP_HI_W = 6;
	localparam int SUB_W     = 2;

	localparam logic [BYTE_W-1:0] PREFIX_MASK   = 8'hC0;
	localparam logic [BYTE_W-1:0] PREFIX_TRIPLE = 8'hC0;
	localparam logic [BYTE_W-1:0] PREFIX_SINGLE = 8'h80;

	// base slots of a three-base byte
	localparam logic [SUB_W-1:0] SUB_FIRST  = 2'd0;
	localparam logic [SUB_W-1:0] SUB_SECOND = 2'd1;
	localparam logic [SUB_W-1:0] SUB_LAST   = 2'd2;

	typedef struct packed {
		logic              emit;
		logic              done;
		logic              last;
		logic [CODE_W-1:0] base_code;
		logic              pend_next;
		logic              load_hi;
	} ndld_ctl_t;

endpackage

// File: rtl/core/nucleotide_diff_list_decoder_top.sv
// ----------------------------------------------------------------------------
// nucleotide_diff_list_decoder_top
// Turns the skip and difference byte list into position and base writes.
// ----------------------------------------------------------------------------
// Each accepted byte is held in an input register and decoded from there. A
// skip byte or a one-base byte leaves that register once decoded, so such
// bytes go through at one per cycle while the output is free; a three-base
// byte holds it until its last base is written, because the single output
// register takes one write per cycle while the output is not stalled.
// The output register lets the next byte be taken while a write
// waits. The user must write total_length through the cfg port only while
// the block is idle; the block itself does not enforce it. Writes at or past
// total_length come out with in_range low and are meant to be dropped. Reset
// clears the position, any pending skip and total_length.
module nucleotide_diff_list_decoder_top import ndld_pkg::*; #(
	parameter int POS_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [LEN_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    code_byte,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_POS_W-1:0] write_pos,
	output logic [CODE_W-1:0]    base_code,
	output logic                 in_range,
	output logic                 last
);

	localparam int CMP_W = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;

	logic [LEN_W-1:0]     total_length_q;
	logic                 valid_s1;
	logic [BYTE_W-1:0]    code_byte_s1;
	logic                 restart_s1;
	logic [SUB_W-1:0]     sub_q;
	logic [POS_BITS-1:0]  pos_q;
	logic                 pend_q;
	logic [SKIP_HI_W-1:0] skip_hi_q;

	logic                 out_valid_q;
	logic [OUT_POS_W-1:0] write_pos_q;
	logic [CODE_W-1:0]    base_code_q;
	logic                 in_range_q;
	logic                 last_q;

	ndld_ctl_t            ctl;
	logic [POS_BITS-1:0]  pos_cur;
	logic [POS_BITS-1:0]  pos_next;
	logic [CMP_W-1:0]     pos_ext;
	logic                 out_free;
	logic                 fire;
	logic                 done_now;

	ndld_decode #(
		.POS_BITS (POS_BITS)
	) u_decode (
		.code_byte (code_byte_s1),
		.restart   (restart_s1),
		.sub       (sub_q),
		.pos       (pos_q),
		.pend      (pend_q),
		.skip_hi   (skip_hi_q),
		.ctl       (ctl),
		.pos_cur   (pos_cur),
		.pos_next  (pos_next)
	);

	assign pos_ext   = CMP_W'(pos_cur);
	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && (!ctl.emit || out_free);
	assign done_now  = fire && ctl.done;
	assign in_stall  = valid_s1 && !done_now;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			total_length_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			code_byte_s1 <= code_byte;
			restart_s1   <= restart;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q     <= SUB_FIRST;
			pos_q     <= '0;
			pend_q    <= 1'b0;
			skip_hi_q <= '0;
		end else if (fire) begin
			sub_q  <= ctl.done ? SUB_FIRST : sub_q + SUB_W'(1);
			pos_q  <= pos_next;
			pend_q <= ctl.pend_next;
			if (ctl.load_hi) begin
				skip_hi_q <= code_byte_s1[SKIP_HI_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl.emit) begin
			write_pos_q <= pos_ext[OUT_POS_W-1:0];
			base_code_q <= ctl.base_code;
			in_range_q  <= pos_ext < CMP_W'(total_length_q);
			last_q      <= ctl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign write_pos = write_pos_q;
	assign base_code = base_code_q;
	assign in_range  = in_range_q;
	assign last      = last_q;

endmodule

// File: rtl/core/ndld_decode.sv
// ----------------------------------------------------------------------------
// ndld_decode
// Decodes one step of the held byte: a base write, a skip start or a skip
// completion, with the next write position.
// ----------------------------------------------------------------------------
module ndld_decode import ndld_pkg::*; #(
	parameter int POS_BITS = 24
) (
	input  logic [BYTE_W-1:0]    code_byte,
	input  logic                 restart,
	input  logic [SUB_W-1:0]     sub,
	input  logic [POS_BITS-1:0]  pos,
	input  logic                 pend,
	input  logic [SKIP_HI_W-1:0] skip_hi,
	output ndld_ctl_t            ctl,
	output logic [POS_BITS-1:0]  pos_cur,
	output logic [POS_BITS-1:0]  pos_next
);

	logic                             clear;
	logic                             pend_cur;
	logic [SKIP_HI_W+BYTE_W-1:0]      adv;

	assign adv = {skip_hi, code_byte};

	always_comb begin
		// restart only acts before the first base of the byte
		clear    = restart && (sub == SUB_FIRST);
		pos_cur  = clear ? '0 : pos;
		pend_cur = clear ? 1'b0 : pend;
		ctl      = '0;
		pos_next = pos_cur;
		if (pend_cur) begin
			ctl.done = 1'b1;
			pos_next = pos_cur + POS_BITS'(adv);
		end else begin
			case (code_byte & PREFIX_MASK)
				PREFIX_TRIPLE: begin
					ctl.emit = 1'b1;
					ctl.last = (sub == SUB_LAST);
					ctl.done = (sub == SUB_LAST);
					case (sub)
						SUB_FIRST:  ctl.base_code = code_byte[5:4];
						SUB_SECOND: ctl.base_code = code_byte[3:2];
						default:    ctl.base_code = code_byte[1:0];
					endcase
					pos_next = pos_cur + POS_BITS'(1);
				end
				PREFIX_SINGLE: begin
					ctl.emit      = 1'b1;
					ctl.last      = 1'b1;
					ctl.done      = 1'b1;
					ctl.base_code = code_byte[1:0];
					pos_next      = pos_cur + POS_BITS'(1);
				end
				default: begin
					ctl.done      = 1'b1;
					ctl.load_hi   = 1'b1;
					ctl.pend_next = 1'b1;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/ndld_checker.sv
// ----------------------------------------------------------------------------
// ndld_checker
// Port-level checks of the list decoder output, bound to the top level.
// ----------------------------------------------------------------------------
module ndld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [23:0] write_pos,
	input logic [1:0]  base_code,
	input logic        in_range,
	input logic        last
);

	// a stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(write_pos)
			&& $stable(base_code) && $stable(last) && $stable(in_range))
	else $error("stalled output beat changed");

	// bases of a three-base byte follow each other at consecutive positions
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			out_valid && (write_pos == $past(write_pos) + 24'd1))
	else $error("three-base byte did not continue at the next position");

	// a byte with bases is held while one of its earlier bases is stuck at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && !last |-> in_stall)
	else $error("new byte taken before the last base of a byte");

endmodule

bind nucleotide_diff_list_decoder_top ndld_checker u_ndld_checker (.*);
